// ===== design/software_timer_pool_assert.svh =====
// Assertion macros shared by the timer pool checker.
// Expects clk and rst_n to be visible where the macros are used.
`ifndef SOFTWARE_TIMER_POOL_ASSERT_SVH
`define SOFTWARE_TIMER_POOL_ASSERT_SVH

// Clocked property, switched off while reset is asserted.
`define STP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold while reset is asserted.
`define STP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/stp_pkg.sv =====
// Types and fixed constants for the software timer pool.
// No dependencies; imported by every module of the block.
`default_nettype none

package stp_pkg;

    localparam int PERIOD_W    = 31;
    localparam int COUNT_W     = 32;
    localparam int MAX_RESULTS = 16;
    localparam int EVC_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_START    = 2'd1,
        OP_STOP     = 2'd2,
        OP_STOP_ALL = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_ONESHOT = 2'd1,
        MODE_CYCLIC  = 2'd2,
        MODE_INVALID = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_BAD_MODE  = 2'd1,
        STS_FULL      = 2'd2,
        STS_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PLAIN   = 2'd1,
        EV_ONESHOT = 2'd2,
        EV_CYCLIC  = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_SCAN,
        S_TICK_UPD,
        S_TICK_END,
        S_START_SCAN,
        S_RESP
    } state_t;

    // one memory word per slot
    typedef struct packed {
        mode_t                mode;
        logic                 routine;
        logic [PERIOD_W-1:0]  period;
        logic [COUNT_W-1:0]   remaining;
    } slot_entry_t;

    // outcome of one tick on one slot
    typedef struct packed {
        logic [COUNT_W-1:0]   remaining;
        logic                 expired;
        event_t               ev;
        logic                 call;
        logic                 rel;
    } tick_upd_t;

    // one result beat
    typedef struct packed {
        status_t     status;
        logic [3:0]  slot;
        event_t      event_res;
        logic        call_routine;
        logic        released;
        logic        last;
    } beat_t;

endpackage

`default_nettype wire

// ===== design/stp_slot_ram.sv =====
// Slot memory: one write port, one read port, registered read data.
// Depends on stp_pkg for the entry layout.
`default_nettype none

module stp_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_W-1:0]    wr_addr,
    input  wire stp_pkg::slot_entry_t wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_W-1:0]    rd_addr,
    output      stp_pkg::slot_entry_t rd_data
);
    import stp_pkg::*;

    slot_entry_t mem [DEPTH];
    slot_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/stp_tick_update.sv =====
// Per-slot tick arithmetic: saturating decrement, expiry test, reload.
// Depends on stp_pkg.
`default_nettype none

module stp_tick_update (
    input  wire stp_pkg::slot_entry_t entry,
    output      stp_pkg::tick_upd_t   upd
);
    import stp_pkg::*;

    localparam logic [COUNT_W-1:0] MOST_NEG = {1'b1, {(COUNT_W-1){1'b0}}};

    logic [COUNT_W-1:0] dec;
    logic [COUNT_W-1:0] reloaded;
    logic               expired;

    // saturates at the most negative count
    assign dec      = (entry.remaining == MOST_NEG) ? entry.remaining
                                                    : entry.remaining - COUNT_W'(1);
    assign expired  = (dec == '0) || dec[COUNT_W-1];
    assign reloaded = dec + {1'b0, entry.period};

    always_comb
    begin
        upd.remaining = dec;
        upd.expired   = expired;
        upd.ev        = EV_NONE;
        upd.call      = 1'b0;
        upd.rel       = 1'b0;
        if (expired)
        begin
            case (entry.mode)
                MODE_PLAIN:
                begin
                    upd.ev  = EV_PLAIN;
                    upd.rel = 1'b1;
                end
                MODE_ONESHOT:
                begin
                    upd.ev        = EV_ONESHOT;
                    upd.rel       = 1'b1;
                    upd.call      = entry.routine;
                    upd.remaining = reloaded;
                end
                MODE_CYCLIC:
                begin
                    upd.ev        = EV_CYCLIC;
                    upd.call      = entry.routine;
                    upd.remaining = reloaded;
                end
                default:
                begin
                    upd.rel = 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/software_timer_pool.sv =====
// Software timer pool: in-use flags, slot memory and the item sequencer.
// Depends on stp_pkg, stp_slot_ram and stp_tick_update.
//
// Usage
//   Item channel (item_valid/item_ready): op selects tick, start, stop or
//   stop-all; mode, period and has_routine matter for start, timer_index
//   for stop. One item is worked on at a time; item_ready is high only
//   while the sequencer is idle.
//   Result channel (result_valid/result_ready): every item gives one or
//   more beats, the final one with last set. A tick gives one beat per
//   expired slot in index order (at most 16), or a single quiet beat.
//   Stop and stop-all go straight to the response beat; start scans from
//   slot 0 up to the first free slot, or to the end when the pool is full;
//   a tick scans every slot, and each active slot costs a memory read and
//   a read-modify-write through the single slot memory.
//   Results leave through an output register, so the next item is taken
//   while the previous final beat still waits. A stalled receiver holds
//   the sequencer only when another beat has to be pushed.
//   Reset clears all in-use flags at once; the slot memory needs no clear,
//   as an entry is read only for a slot in use, which start has written.
`default_nettype none

module software_timer_pool #(
    parameter int TIMER_COUNT = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output      logic        item_ready,
    input  wire logic [1:0]  op,
    input  wire logic [1:0]  mode,
    input  wire logic [30:0] period,
    input  wire logic        has_routine,
    input  wire logic [5:0]  timer_index,
    output      logic        result_valid,
    input  wire logic        result_ready,
    output      logic [1:0]  status,
    output      logic [3:0]  slot,
    output      logic [1:0]  event_res,
    output      logic        call_routine,
    output      logic        released,
    output      logic        last
);
    import stp_pkg::*;

    localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CNT_W = $clog2(TIMER_COUNT + 1);
    localparam logic [CNT_W-1:0] IDX_END = CNT_W'(TIMER_COUNT);
    localparam logic [6:0]       COUNT_7 = 7'(TIMER_COUNT);

    // sequencer state
    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [TIMER_COUNT-1:0]  in_use_reg, in_use_next;
    logic [EVC_W-1:0]        ev_cnt_reg, ev_cnt_next;
    logic                    held_valid_reg, held_valid_next;
    beat_t                   held_reg, held_next;
    beat_t                   resp_reg, resp_next;

    // captured item
    mode_t                   mode_reg, mode_next;
    logic [PERIOD_W-1:0]     period_reg, period_next;
    logic                    routine_reg, routine_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    beat_t                   out_reg, out_next;

    // memory ports
    logic                    wr_en, rd_en;
    logic [IDX_W-1:0]        wr_addr;
    slot_entry_t             wr_data, rd_data;

    tick_upd_t               upd;
    logic [IDX_W-1:0]        idx;
    logic                    out_free;
    logic                    slot_busy;
    logic                    scan_done;
    logic                    keep_event;
    logic                    upd_go;
    logic                    stop_ok;
    beat_t                   push_beat;
    logic                    push;

    stp_slot_ram #(
        .DEPTH  (TIMER_COUNT),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx),
        .rd_data (rd_data)
    );

    stp_tick_update u_upd (
        .entry (rd_data),
        .upd   (upd)
    );

    assign idx        = idx_reg[IDX_W-1:0];
    assign out_free   = !out_valid_reg || result_ready;
    assign scan_done  = (idx_reg == IDX_END);
    assign slot_busy  = in_use_reg[idx];
    // events past the result limit still update the slot but are dropped
    assign keep_event = (ev_cnt_reg < EVC_W'(MAX_RESULTS));
    // an expiry that has to push the held beat waits for the output register
    assign upd_go     = !(upd.expired && keep_event && held_valid_reg) || out_free;
    assign stop_ok    = !timer_index[5] && ({2'b00, timer_index[4:0]} < COUNT_7);

    assign item_ready = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (op_t'(op))
                        OP_TICK:  state_next = S_TICK_SCAN;
                        OP_START: state_next = S_START_SCAN;
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_TICK_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_TICK_END;
                end
                else if (slot_busy)
                begin
                    state_next = S_TICK_UPD;
                end
            end
            S_TICK_UPD:
            begin
                if (upd_go)
                begin
                    state_next = S_TICK_SCAN;
                end
            end
            S_TICK_END:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_START_SCAN:
            begin
                if (scan_done || !slot_busy)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        idx_next        = idx_reg;
        in_use_next     = in_use_reg;
        ev_cnt_next     = ev_cnt_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        resp_next       = resp_reg;
        mode_next       = mode_reg;
        period_next     = period_reg;
        routine_next    = routine_reg;
        wr_en           = 1'b0;
        wr_addr         = idx;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        push            = 1'b0;
        push_beat       = resp_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    idx_next        = '0;
                    ev_cnt_next     = '0;
                    held_valid_next = 1'b0;
                    mode_next       = mode_t'(mode);
                    period_next     = period;
                    routine_next    = has_routine;
                    resp_next       = '{STS_OK, 4'd0, EV_NONE, 1'b0, 1'b0, 1'b1};
                    case (op_t'(op))
                        OP_STOP:
                        begin
                            if (stop_ok)
                            begin
                                in_use_next[timer_index[IDX_W-1:0]] = 1'b0;
                                resp_next.slot     = timer_index[3:0];
                                resp_next.released = 1'b1;
                            end
                            else
                            begin
                                resp_next.status = STS_BAD_INDEX;
                            end
                        end
                        OP_STOP_ALL:
                        begin
                            in_use_next        = '0;
                            resp_next.released = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_TICK_SCAN:
            begin
                if (!scan_done)
                begin
                    if (slot_busy)
                    begin
                        rd_en = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            S_TICK_UPD:
            begin
                if (upd_go)
                begin
                    wr_en             = 1'b1;
                    wr_data.remaining = upd.remaining;
                    idx_next          = idx_reg + CNT_W'(1);
                    if (upd.expired)
                    begin
                        if (upd.rel)
                        begin
                            in_use_next[idx] = 1'b0;
                        end
                        if (keep_event)
                        begin
                            // the held beat is not the last one, a newer one follows
                            push      = held_valid_reg;
                            push_beat = held_reg;
                            push_beat.last  = 1'b0;
                            held_valid_next = 1'b1;
                            held_next = '{STS_OK, 4'(idx_reg), upd.ev, upd.call,
                                          upd.rel, 1'b0};
                            ev_cnt_next = ev_cnt_reg + EVC_W'(1);
                        end
                    end
                end
            end
            S_TICK_END:
            begin
                push = out_free;
                if (held_valid_reg)
                begin
                    push_beat      = held_reg;
                    push_beat.last = 1'b1;
                end
                else
                begin
                    push_beat = '{STS_OK, 4'd0, EV_NONE, 1'b0, 1'b0, 1'b1};
                end
            end
            S_START_SCAN:
            begin
                if (scan_done)
                begin
                    resp_next.status = STS_FULL;
                end
                else if (!slot_busy)
                begin
                    if (mode_reg == MODE_INVALID)
                    begin
                        resp_next.status = STS_BAD_MODE;
                    end
                    else
                    begin
                        wr_en             = 1'b1;
                        wr_data.mode      = mode_reg;
                        wr_data.routine   = routine_reg;
                        wr_data.period    = period_reg;
                        wr_data.remaining = {1'b0, period_reg};
                        in_use_next[idx]  = 1'b1;
                        resp_next.slot    = 4'(idx_reg);
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_RESP:
            begin
                push      = out_free;
                push_beat = resp_reg;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = push_beat;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            in_use_reg     <= '0;
            ev_cnt_reg     <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            in_use_reg     <= in_use_next;
            ev_cnt_reg     <= ev_cnt_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg    <= held_next;
        resp_reg    <= resp_next;
        mode_reg    <= mode_next;
        period_reg  <= period_next;
        routine_reg <= routine_next;
        out_reg     <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign slot         = out_reg.slot;
    assign event_res    = out_reg.event_res;
    assign call_routine = out_reg.call_routine;
    assign released     = out_reg.released;
    assign last         = out_reg.last;

endmodule

`default_nettype wire

// ===== design/stp_checker.sv =====
// Port-level checks for the software timer pool, bound to the top level.
// Depends on stp_pkg and software_timer_pool_assert.svh.
`default_nettype none

module stp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_ready,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [1:0]  status,
    input wire logic [3:0]  slot,
    input wire logic [1:0]  event_res,
    input wire logic        call_routine,
    input wire logic        released,
    input wire logic        last
);
    import stp_pkg::*;

`include "software_timer_pool_assert.svh"

    // a result beat waits until taken
    `STP_ASSERT(a_result_held, result_valid && !result_ready |=> result_valid,
                "result beat dropped")

    // error beats are single and carry no slot or event
    `STP_ASSERT(a_error_clean,
                result_valid && (status != STS_OK) |->
                    (slot == 4'd0) && (event_res == EV_NONE) && !released && last,
                "error beat malformed")

    // a routine call only comes with a one-shot or cyclic expiry
    `STP_ASSERT(a_call_event,
                result_valid && call_routine |->
                    (event_res == EV_ONESHOT) || (event_res == EV_CYCLIC),
                "routine call without firing")

    // one item at a time: the sequencer leaves idle once an item is taken
    `STP_ASSERT(a_one_item, item_valid && item_ready |=> !item_ready,
                "second item taken while busy")

    // an edge seen in reset leaves no result pending
    `STP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !result_valid,
                       "result valid after reset")

endmodule

bind software_timer_pool stp_checker u_stp_checker (.*);

`default_nettype wire
